// ===== hdl/lphm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_pkg - shared types and constants of the linear probing hash map
// Table geometry, slot word layout, state encoding and command codes.
// ----------------------------------------------------------------------------
package lphm_pkg;

	localparam int SLOT_BITS   = 10;
	localparam int KEY_WIDTH   = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int TABLE_SLOTS = 1 << SLOT_BITS;

	// stored_count and entry_limit share this width
	localparam int CNT_WIDTH = 11;
	localparam int LIMIT_RAW = (TABLE_SLOTS * 9) / 10;
	localparam logic [CNT_WIDTH-1:0] LIMIT_RESET =
		CNT_WIDTH'((LIMIT_RAW > 2047) ? 2047 : LIMIT_RAW);

	localparam logic [63:0] HASH_MULT = 64'd484391091;

	// command codes; the unused code acts as a query
	localparam logic [1:0] FUNC_QUERY = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_WRITE = 2'd2;

	// configuration register indexes
	localparam logic [0:0] REG_EMPTY_KEY   = 1'd0;
	localparam logic [0:0] REG_ENTRY_LIMIT = 1'd1;

	typedef logic [SLOT_BITS-1:0] slot_addr_t;

	typedef struct packed {
		logic                   used;
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
	} slot_t;

	typedef struct packed {
		logic       en;
		slot_addr_t addr;
		slot_t      data;
	} slot_wr_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PROBE
	} state_t;

	// home slot: only the low SLOT_BITS bits of the product matter, so a
	// SLOT_BITS x SLOT_BITS multiply truncated to SLOT_BITS bits is exact
	function automatic slot_addr_t hash_slot(input logic [KEY_WIDTH-1:0] k);
		slot_addr_t a;
		slot_addr_t b;
		a = k[SLOT_BITS-1:0];
		b = HASH_MULT[SLOT_BITS-1:0];
		return slot_addr_t'(a * b);
	endfunction

endpackage

// ===== hdl/lphm_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_table - slot memory of the hash map
// One write port, one read port with registered data. After reset a sweep
// marks every slot empty, one slot per cycle, while clear_busy is high.
// ----------------------------------------------------------------------------
module lphm_table (
	input  logic               clk,
	input  logic               arst_n,
	input  lphm_pkg::slot_addr_t rd_addr,
	output lphm_pkg::slot_t    rd_data,
	input  lphm_pkg::slot_wr_t wr,
	output logic               clear_busy
);
	import lphm_pkg::*;

	slot_t      mem [TABLE_SLOTS];
	slot_t      rd_q;
	slot_addr_t clr_addr_q;
	logic       clearing_q;

	// clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == slot_addr_t'(TABLE_SLOTS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// memory array: sweep writes take the port while clearing
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data    = rd_q;
	assign clear_busy = clearing_q;

endmodule

// ===== hdl/linear_probe_hash_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_map - key/value map with linear probing
// Fixed table of 2^SLOT_BITS slots; lookup, read-with-insert and
// write-with-insert commands, one result word per command.
// ----------------------------------------------------------------------------
// Usage: after reset the block clears its slot memory and holds busy high
// until the sweep is done; configuration writes are taken at any
// time, but should only be made while busy is low. A command is taken when
// start is high and busy is low. The block then reads one slot per cycle from
// the single-port-read slot memory, starting at the home slot, and a command
// visits 1 to 1024 slots while busy is high; the result word appears with
// done for one cycle right after, and in that same cycle the next start can
// be taken. A key equal to the empty marker skips the probe and answers
// in the cycle after start.
// Results cannot be stalled: sample them whenever done is high.
// ----------------------------------------------------------------------------
module linear_probe_hash_map (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_wr_en,
	input  logic [0:0]                       cfg_index,
	input  logic [lphm_pkg::KEY_WIDTH-1:0]   cfg_wdata,
	// command
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       func,
	input  logic [lphm_pkg::KEY_WIDTH-1:0]   key,
	input  logic [lphm_pkg::VALUE_WIDTH-1:0] value_in,
	// result
	output logic                             done,
	output logic                             present,
	output logic [lphm_pkg::VALUE_WIDTH-1:0] value_out,
	output logic                             refused
);
	import lphm_pkg::*;

	state_t state_q, state_nxt;

	logic [KEY_WIDTH-1:0]   empty_key_q;
	logic [CNT_WIDTH-1:0]   entry_limit_q;
	logic [CNT_WIDTH-1:0]   stored_count_q;

	logic [1:0]             func_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	slot_addr_t             pos_q;
	logic [SLOT_BITS:0]     probe_cnt_q;

	logic                   done_q;
	logic                   present_q;
	logic [VALUE_WIDTH-1:0] value_out_q;
	logic                   refused_q;

	slot_t    rd_data;
	slot_addr_t rd_addr;
	slot_wr_t wr;
	logic     clear_busy;

	logic accept, key_is_empty, ins_q, ins_in;
	logic fin, fin_present, fin_refused, count_inc;
	logic [VALUE_WIDTH-1:0] fin_value;
	logic slot_hit, slot_empty, last_probe;

	lphm_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr         (wr),
		.clear_busy (clear_busy)
	);

	assign accept       = start && (state_q == ST_IDLE);
	assign key_is_empty = (key == empty_key_q);
	assign ins_in       = (func == FUNC_READ) || (func == FUNC_WRITE);
	assign ins_q        = (func_q == FUNC_READ) || (func_q == FUNC_WRITE);

	// slot under test in the probe state is the one at pos_q
	assign slot_empty = !rd_data.used;
	assign slot_hit   = rd_data.used && (rd_data.key == key_q);
	assign last_probe = (probe_cnt_q == (SLOT_BITS+1)'(TABLE_SLOTS - 1));

	// next read: home slot on accept, else the following slot
	assign rd_addr = (state_q == ST_IDLE) ? hash_slot(key) : pos_q + 1'b1;

	// next state, slot update and result
	always_comb begin
		state_nxt   = state_q;
		fin         = 1'b0;
		fin_present = 1'b0;
		fin_refused = 1'b0;
		fin_value   = '0;
		count_inc   = 1'b0;
		wr.en       = 1'b0;
		wr.addr     = pos_q;
		wr.data     = rd_data;
		case (state_q)
			ST_CLEAR: begin
				if (!clear_busy) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (key_is_empty) begin
						fin         = 1'b1;
						fin_refused = ins_in;
					end else begin
						state_nxt = ST_PROBE;
					end
				end
			end
			ST_PROBE: begin
				if (slot_hit) begin
					fin         = 1'b1;
					fin_present = 1'b1;
					fin_value   = rd_data.value;
					if (func_q == FUNC_WRITE) begin
						wr.en         = 1'b1;
						wr.data.value = val_q;
						fin_value     = val_q;
					end
				end else if (slot_empty) begin
					fin = 1'b1;
					if (ins_q) begin
						if (stored_count_q >= entry_limit_q) begin
							fin_refused = 1'b1;
						end else begin
							wr.en      = 1'b1;
							wr.data.used  = 1'b1;
							wr.data.key   = key_q;
							wr.data.value = (func_q == FUNC_WRITE) ? val_q : '0;
							fin_value  = wr.data.value;
							count_inc  = 1'b1;
						end
					end
				end else if (last_probe) begin
					// table full without a match
					fin         = 1'b1;
					fin_refused = ins_q;
				end
				if (fin) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_key_q   <= '0;
			entry_limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_EMPTY_KEY:   empty_key_q   <= cfg_wdata;
				REG_ENTRY_LIMIT: entry_limit_q <= cfg_wdata[CNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// control: stored count, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count_q <= '0;
			done_q         <= 1'b0;
		end else begin
			done_q <= fin;
			if (count_inc) begin
				stored_count_q <= stored_count_q + 1'b1;
			end
		end
	end

	// command word and probe position
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q      <= func;
			key_q       <= key;
			val_q       <= value_in;
			pos_q       <= hash_slot(key);
			probe_cnt_q <= '0;
		end else if (state_q == ST_PROBE) begin
			pos_q       <= pos_q + 1'b1;
			probe_cnt_q <= probe_cnt_q + 1'b1;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (fin) begin
			present_q   <= fin_present;
			value_out_q <= fin_value;
			refused_q   <= fin_refused;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign present   = present_q;
	assign value_out = value_out_q;
	assign refused   = refused_q;

`ifndef NO_ASSERTIONS
	// a result is never both a hit and a refusal
	a_hit_not_refused: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(present_q && refused_q))
		else $error("result both present and refused");

	// a refused command leaves the stored count alone
	a_refused_no_insert: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && refused_q |-> stored_count_q == $past(stored_count_q))
		else $error("refused command changed stored count");

	// no results while the slot memory is being cleared
	a_no_done_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !done_q)
		else $error("result during clearing sweep");

	// the count never exceeds the table size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_count_q <= CNT_WIDTH'(TABLE_SLOTS))
		else $error("stored count beyond table size");
`endif

endmodule
